[sv/record_text_tokenizer_assert.svh]
// Assertion macros for the record text tokenizer checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef RECORD_TEXT_TOKENIZER_ASSERT_SVH
`define RECORD_TEXT_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RTT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("record_text_tokenizer: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("record_text_tokenizer: next-cycle check failed");

`endif

[sv/rtt_pkg.sv]
// ----------------------------------------------------------------------------
// rtt_pkg
// Shared types, character codes and event codes of the record text tokenizer.
// ----------------------------------------------------------------------------
package rtt_pkg;

  localparam int LINE_BITS  = 16;
  localparam int LINE_OUT_W = 16;
  localparam int KEY_LEN    = 8;
  localparam int KEY_POS_W  = $clog2(KEY_LEN + 1);
  localparam int KEY_IDX_W  = $clog2(KEY_LEN);
  localparam int MAX_RES    = 3;
  localparam int RES_CNT_W  = $clog2(MAX_RES + 1);
  localparam int Q_DEPTH    = 4;
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  typedef enum logic [3:0] {
    EV_CHAR      = 4'd0,
    EV_WORD_END  = 4'd1,
    EV_KEY_END   = 4'd2,
    EV_LBRACE    = 4'd3,
    EV_RBRACE    = 4'd4,
    EV_LPAREN    = 4'd5,
    EV_RPAREN    = 4'd6,
    EV_COMMA     = 4'd7,
    EV_SEMI      = 4'd8,
    EV_EQUAL     = 4'd9,
    EV_INPUT_END = 4'd10
  } ev_code_t;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;

  // The keyword that gets its own end event.
  localparam logic [7:0] KEY_WORD [KEY_LEN] = '{
    8'h43, 8'h48, 8'h49, 8'h4C, 8'h44, 8'h52, 8'h45, 8'h4E
  };

  typedef struct packed {
    logic                  in_word;
    logic                  quoted;
    logic                  escaped;
    logic [7:0]            held_char;
    logic                  held_valid;
    logic [KEY_POS_W-1:0]  key_pos;
    logic                  key_miss;
    logic [LINE_BITS-1:0]  line;
  } lex_state_t;

  typedef struct packed {
    ev_code_t               ev;
    logic [7:0]             ch;
    logic [LINE_OUT_W-1:0]  line;
    logic                   last;
  } res_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]   cnt;
    res_t [MAX_RES-1:0]     res;
  } res_set_t;

  // Punctuation event of a character, EV_CHAR when it is not punctuation.
  function automatic ev_code_t punct_code(logic [7:0] c);
    ev_code_t code;
    case (c)
      CH_LBRACE: code = EV_LBRACE;
      CH_RBRACE: code = EV_RBRACE;
      CH_LPAREN: code = EV_LPAREN;
      CH_RPAREN: code = EV_RPAREN;
      CH_COMMA:  code = EV_COMMA;
      CH_SEMI:   code = EV_SEMI;
      CH_EQUAL:  code = EV_EQUAL;
      default:   code = EV_CHAR;
    endcase
    return code;
  endfunction

endpackage

[sv/rtt_if.sv]
// ----------------------------------------------------------------------------
// rtt_in_if / rtt_out_if
// Valid/ready channels carrying input characters and result events.
// ----------------------------------------------------------------------------
interface rtt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_mark;

  modport source (output valid, output byte_in, output end_mark, input ready);
  modport sink   (input valid, input byte_in, input end_mark, output ready);
endinterface

interface rtt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [7:0]  char_out;
  logic [15:0] line_count;
  logic        last;

  modport source (output valid, output event_res, output char_out,
                  output line_count, output last, input ready);
  modport sink   (input valid, input event_res, input char_out,
                  input line_count, input last, output ready);
endinterface

[sv/record_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// record_text_tokenizer
// Streaming lexer for brace and paren record text, one character per cycle while the result queue has room.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one character (byte_in) or an end mark (end_mark) per
//   transaction. out_ch carries one event per transaction: a word character,
//   a word or keyword end, one of the seven punctuation tokens, or input end,
//   together with the current line number and a flag marking the final event
//   caused by the input transaction.
// Flow and throughput:
//   An accepted character is lexed in the cycle it is taken; its events go
//   into the result queue, which offers them on out_ch. Characters are taken
//   one per cycle while each produces at most one event and the receiver keeps
//   up; a character producing several events occupies the output for one
//   transaction per event, so the sustained rate is one transaction per cycle,
//   set by the single-event output port draining a four-entry result queue.
// Reset:
//   rst (synchronous) empties the result queue, places the lexer between
//   tokens and sets the line count to one.
// Stalls:
//   While out_ch is stalled, events wait in the queue; a further input
//   transaction is still taken while there is room for a full three-event result set.
// ----------------------------------------------------------------------------
module record_text_tokenizer
  import rtt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  rtt_in_if.sink     in_ch,
  rtt_out_if.source  out_ch
);

  // Lexer state register: word flags, held-back character, keyword match
  // progress and the saturating line counter.
  lex_state_t st;
  lex_state_t st_next;
  res_set_t   res_set;
  res_t       head;
  logic       in_ready;
  logic       out_valid;
  logic       in_accept;

  assign in_accept   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  // One pass of the lexer over the incoming character and current state.
  rtt_lex u_lex (
    .st       (st),
    .byte_in  (in_ch.byte_in),
    .end_mark (in_ch.end_mark),
    .st_next  (st_next),
    .res_set  (res_set)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.in_word    <= 1'b0;
      st.quoted     <= 1'b0;
      st.escaped    <= 1'b0;
      st.held_char  <= 8'h00;
      st.held_valid <= 1'b0;
      st.key_pos    <= '0;
      st.key_miss   <= 1'b0;
      st.line       <= LINE_BITS'(1);
    end else if (in_accept) begin
      st <= st_next;
    end
  end

  // The result queue decouples the lexer from a stalling receiver.
  rtt_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .load      (in_accept),
    .res_set   (res_set),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .head      (head),
    .in_ready  (in_ready)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.event_res  = head.ev;
  assign out_ch.char_out   = head.ch;
  assign out_ch.line_count = head.line;
  assign out_ch.last       = head.last;

endmodule

[sv/rtt_lex.sv]
// ----------------------------------------------------------------------------
// rtt_lex
// Combinational lexer step: next state and result events for one character.
// ----------------------------------------------------------------------------
module rtt_lex
  import rtt_pkg::*;
(
  input  lex_state_t st,
  input  logic [7:0] byte_in,
  input  logic       end_mark,
  output lex_state_t st_next,
  output res_set_t   res_set
);

  typedef struct packed {
    lex_state_t s;
    res_set_t   r;
  } work_t;

  function automatic work_t emit(work_t w, ev_code_t ev, logic [7:0] ch);
    work_t o;
    o = w;
    if (o.r.cnt < RES_CNT_W'(MAX_RES)) begin
      o.r.res[o.r.cnt].ev = ev;
      o.r.res[o.r.cnt].ch = ch;
      o.r.cnt = o.r.cnt + RES_CNT_W'(1);
    end
    return o;
  endfunction

  function automatic work_t clear_word(work_t w);
    work_t o;
    o = w;
    o.s.in_word    = 1'b0;
    o.s.quoted     = 1'b0;
    o.s.escaped    = 1'b0;
    o.s.held_char  = 8'h00;
    o.s.held_valid = 1'b0;
    o.s.key_pos    = '0;
    o.s.key_miss   = 1'b0;
    return o;
  endfunction

  function automatic work_t store_char(work_t w, logic [7:0] c);
    work_t o;
    o = w;
    if (o.s.held_valid) begin
      o = emit(o, EV_CHAR, o.s.held_char);
    end
    o.s.held_char  = c;
    o.s.held_valid = 1'b1;
    if (!o.s.key_miss) begin
      if (o.s.key_pos < KEY_POS_W'(KEY_LEN) &&
          c == KEY_WORD[o.s.key_pos[KEY_IDX_W-1:0]]) begin
        o.s.key_pos = o.s.key_pos + KEY_POS_W'(1);
      end else begin
        o.s.key_miss = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic work_t end_word(work_t w);
    work_t o;
    o = w;
    if (o.s.held_valid && !(o.s.quoted && o.s.held_char == CH_QUOTE)) begin
      o = emit(o, EV_CHAR, o.s.held_char);
    end
    if (!o.s.key_miss && o.s.key_pos == KEY_POS_W'(KEY_LEN)) begin
      o = emit(o, EV_KEY_END, 8'h00);
    end else begin
      o = emit(o, EV_WORD_END, 8'h00);
    end
    return clear_word(o);
  endfunction

  function automatic work_t start_word(work_t w, logic [7:0] c);
    work_t o;
    o = clear_word(w);
    o.s.in_word = 1'b1;
    if (c == CH_QUOTE) begin
      o.s.quoted   = 1'b1;
      o.s.key_miss = 1'b1;
    end else begin
      o.s.escaped = (c == CH_BSLASH);
      o = store_char(o, c);
    end
    return o;
  endfunction

  function automatic work_t bump_line(work_t w);
    work_t o;
    o = w;
    if (o.s.line != '1) begin
      o.s.line = o.s.line + LINE_BITS'(1);
    end
    return o;
  endfunction

  work_t    w;
  logic     white;
  logic     closing;
  logic     done;
  ev_code_t pc;

  always_comb begin
    w       = '0;
    w.s     = st;
    white   = (byte_in == CH_SPACE) || (byte_in == CH_TAB) || (byte_in == CH_NL);
    pc      = punct_code(byte_in);
    closing = 1'b0;
    done    = 1'b0;

    if (end_mark) begin
      if (st.in_word) begin
        w = end_word(w);
      end
      w = emit(w, EV_INPUT_END, 8'h00);
    end else if (st.in_word) begin
      if (byte_in == CH_NL) begin
        w = bump_line(w);
      end
      if (!st.escaped && !st.quoted) begin
        if (white) begin
          w    = end_word(w);
          done = 1'b1;
        end else if (pc != EV_CHAR && pc != EV_EQUAL) begin
          w    = end_word(w);
          w    = emit(w, pc, 8'h00);
          done = 1'b1;
        end else if (byte_in == CH_QUOTE) begin
          w    = end_word(w);
          w    = start_word(w, byte_in);
          done = 1'b1;
        end
      end
      if (!done) begin
        closing = !st.escaped && st.quoted && (byte_in == CH_QUOTE);
        if (st.escaped) begin
          w.s.escaped = 1'b0;
          w = store_char(w, byte_in);
        end else if (byte_in == CH_BSLASH) begin
          w.s.escaped = 1'b1;
        end else begin
          w = store_char(w, byte_in);
        end
        if (closing) begin
          w = end_word(w);
        end
      end
    end else begin
      if (white) begin
        if (byte_in == CH_NL) begin
          w = bump_line(w);
        end
      end else if (pc != EV_CHAR) begin
        w = emit(w, pc, 8'h00);
      end else begin
        w = start_word(w, byte_in);
      end
    end

    // Every result of the item reports the line count after the item.
    for (int j = 0; j < MAX_RES; j++) begin
      w.r.res[j].line = LINE_OUT_W'(w.s.line);
      w.r.res[j].last = (w.r.cnt == RES_CNT_W'(j + 1));
    end
  end

  assign st_next = w.s;
  assign res_set = w.r;

endmodule

[sv/rtt_outq.sv]
// ----------------------------------------------------------------------------
// rtt_outq
// Result queue: takes up to three events at once and hands out one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module rtt_outq
  import rtt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  res_set_t res_set,
  input  logic     out_ready,
  output logic     out_valid,
  output res_t     head,
  output logic     in_ready
);

  res_t               q      [Q_DEPTH];
  res_t               q_next [Q_DEPTH];
  logic [Q_CNT_W-1:0] cnt;
  logic [Q_CNT_W-1:0] cnt_next;
  logic [Q_CNT_W-1:0] cnt_after;
  logic               pop;

  assign out_valid = (cnt != '0);
  assign pop       = out_valid && out_ready;
  assign cnt_after = cnt - Q_CNT_W'(pop);
  // A new item may need room for a full set of results.
  assign in_ready  = (cnt_after <= Q_CNT_W'(Q_DEPTH - MAX_RES));
  assign head      = q[0];

  always_comb begin
    q_next = q;
    if (pop) begin
      for (int k = 0; k < Q_DEPTH - 1; k++) begin
        q_next[k] = q[k + 1];
      end
    end
    if (load) begin
      for (int k = 0; k < Q_DEPTH; k++) begin
        for (int j = 0; j < MAX_RES; j++) begin
          if (RES_CNT_W'(j) < res_set.cnt &&
              (cnt_after + Q_CNT_W'(j)) == Q_CNT_W'(k)) begin
            q_next[k] = res_set.res[j];
          end
        end
      end
    end
    cnt_next = cnt_after + (load ? Q_CNT_W'(res_set.cnt) : Q_CNT_W'(0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

[sv/rtt_checker.sv]
// ----------------------------------------------------------------------------
// rtt_checker
// Port-level checks of the record text tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "record_text_tokenizer_assert.svh"

module rtt_checker
  import rtt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  rtt_in_if.sink     in_ch,
  rtt_out_if.source  out_ch
);

  logic out_stall;

  assign out_stall = out_ch.valid && !out_ch.ready;

  // A stalled event stays offered and unchanged.
  `RTT_ASSERT_NEXT(a_out_hold, out_stall, out_ch.valid && $stable(out_ch.event_res) && $stable(out_ch.char_out) && $stable(out_ch.line_count) && $stable(out_ch.last))

  // Input end is always the final event of its transaction.
  `RTT_ASSERT_NOW(a_end_last, out_ch.valid && out_ch.event_res == EV_INPUT_END, out_ch.last)

  // Only word character events carry a character.
  `RTT_ASSERT_NOW(a_char_zero, out_ch.valid && out_ch.event_res != EV_CHAR, out_ch.char_out == 8'h00)

  // Line numbering starts at one and never wraps to zero.
  `RTT_ASSERT_NOW(a_line_nz, out_ch.valid, out_ch.line_count != 16'h0000)

  // With no event waiting, the block always takes a new character.
  `RTT_ASSERT_NOW(a_in_ready_empty, !out_ch.valid, in_ch.ready)

endmodule

bind record_text_tokenizer rtt_checker u_rtt_checker (
  .clk    (clk),
  .rst    (rst),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
